// File: hdl/binary_min_heap_queue_assert.svh
// ----------------------------------------------------------------------------
// binary_min_heap_queue assertion macros
// Concurrent assertion shorthands, sampled on clk, quiet while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef BINARY_MIN_HEAP_QUEUE_ASSERT_SVH
`define BINARY_MIN_HEAP_QUEUE_ASSERT_SVH

// check prop in the same cycle as cond
`define BHQ_ASSERT_SAME(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// check prop in the cycle after cond
`define BHQ_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// File: hdl/bhq_pkg.sv
// ----------------------------------------------------------------------------
// bhq_pkg
// Shared types and constants of the binary min-heap queue.
// ----------------------------------------------------------------------------
package bhq_pkg;

	localparam int PRIO_W   = 16;
	localparam int TAG_W    = 24;
	localparam int FILL_W   = 11;
	localparam int ENTRY_W  = PRIO_W + TAG_W;
	localparam int S_DATA_W = 40;
	localparam int M_DATA_W = 56;

	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [PRIO_W-1:0] prio;
	} entry_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		ACT_PUSH = 1'b0,
		ACT_POP  = 1'b1
	} action_t;

	typedef enum logic [2:0] {
		RA_ROOT,
		RA_LAST,
		RA_PARENT,
		RA_LEFT,
		RA_RIGHT
	} raddr_sel_t;

	typedef enum logic [1:0] {
		WD_HOLD,
		WD_READ,
		WD_LEFT
	} wdata_sel_t;

	typedef struct packed {
		logic       start;
		logic       rd_en;
		raddr_sel_t rd_sel;
		logic       wr_en;
		wdata_sel_t wr_sel;
		logic       step_up;
		logic       step_left;
		logic       step_right;
		logic       cap_res;
		logic       cap_hold;
		logic       cap_left;
		logic       load_out;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic at_root;
		logic up_less;
		logic leaf;
		logic has_right;
		logic dn_left;
		logic dn_right;
	} sts_t;

endpackage

// File: hdl/bhq_ram.sv
// ----------------------------------------------------------------------------
// bhq_ram
// Single write port, single read port heap store with registered read data.
// ----------------------------------------------------------------------------
module bhq_ram
	import bhq_pkg::*;
#(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  entry_t        wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output entry_t        rd_data
);

	entry_t mem [DEPTH];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: hdl/bhq_dp.sv
// ----------------------------------------------------------------------------
// bhq_dp
// Heap datapath: entry count, sift index, held entries, compares and result.
// ----------------------------------------------------------------------------
module bhq_dp
	import bhq_pkg::*;
#(
	parameter int HEAP_DEPTH = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  action_t           action,
	input  entry_t            in_entry,
	output status_t           out_status,
	output entry_t            out_entry,
	output logic [FILL_W-1:0] out_fill
);

	localparam int PW = $clog2(HEAP_DEPTH + 1);
	localparam int IW = PW + 1;
	localparam int AW = $clog2(HEAP_DEPTH);

	logic [PW-1:0]     cnt_q;
	logic [PW-1:0]     idx_q;
	entry_t            hold_q;
	entry_t            left_q;
	entry_t            res_q;
	status_t           stat_q;
	status_t           out_stat_q;
	entry_t            out_entry_q;
	logic [FILL_W-1:0] out_fill_q;

	entry_t            rd_data;
	entry_t            wr_data;
	logic [IW-1:0]     child_l;
	logic [IW-1:0]     child_r;
	logic [IW-1:0]     rd_pos;
	logic [AW-1:0]     rd_addr;
	logic [AW-1:0]     wr_addr;
	logic [PRIO_W-1:0] cand_prio;

	assign child_l = {idx_q, 1'b0};
	assign child_r = {idx_q, 1'b1};

	assign sts.full      = (cnt_q == PW'(HEAP_DEPTH));
	assign sts.empty     = (cnt_q == '0);
	assign sts.at_root   = (idx_q == PW'(1));
	assign sts.up_less   = (hold_q.prio < rd_data.prio);
	assign sts.leaf      = (child_l > IW'(cnt_q));
	assign sts.has_right = (child_r <= IW'(cnt_q));
	assign sts.dn_left   = (left_q.prio < hold_q.prio);
	assign cand_prio     = sts.dn_left ? left_q.prio : hold_q.prio;
	assign sts.dn_right  = sts.has_right && (rd_data.prio < cand_prio);

	always_comb begin
		unique case (cmd.rd_sel)
			RA_ROOT:   rd_pos = IW'(1);
			RA_LAST:   rd_pos = IW'(cnt_q);
			RA_PARENT: rd_pos = IW'(idx_q >> 1);
			RA_LEFT:   rd_pos = child_l;
			RA_RIGHT:  rd_pos = child_r;
			default:   rd_pos = IW'(1);
		endcase
	end

	always_comb begin
		unique case (cmd.wr_sel)
			WD_HOLD: wr_data = hold_q;
			WD_READ: wr_data = rd_data;
			WD_LEFT: wr_data = left_q;
			default: wr_data = hold_q;
		endcase
	end

	assign rd_addr = AW'(rd_pos - IW'(1));
	assign wr_addr = AW'(idx_q - PW'(1));

	bhq_ram #(
		.DEPTH (HEAP_DEPTH),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (cmd.wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (cmd.rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.start && action == ACT_PUSH && !sts.full) begin
			cnt_q <= cnt_q + PW'(1);
		end else if (cmd.cap_hold) begin
			cnt_q <= cnt_q - PW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			res_q <= '0;
			if (action == ACT_PUSH) begin
				if (sts.full) begin
					stat_q <= ST_FULL;
				end else begin
					stat_q <= ST_DONE;
					hold_q <= in_entry;
					idx_q  <= cnt_q + PW'(1);
				end
			end else begin
				stat_q <= sts.empty ? ST_EMPTY : ST_DONE;
			end
		end
		if (cmd.cap_res) begin
			res_q <= rd_data;
		end
		if (cmd.cap_hold) begin
			hold_q <= rd_data;
			idx_q  <= PW'(1);
		end
		if (cmd.cap_left) begin
			left_q <= rd_data;
		end
		if (cmd.step_up) begin
			idx_q <= idx_q >> 1;
		end else if (cmd.step_left) begin
			idx_q <= PW'(child_l);
		end else if (cmd.step_right) begin
			idx_q <= PW'(child_r);
		end
		if (cmd.load_out) begin
			out_stat_q  <= stat_q;
			out_entry_q <= res_q;
			out_fill_q  <= FILL_W'(cnt_q);
		end
	end

	assign out_status = out_stat_q;
	assign out_entry  = out_entry_q;
	assign out_fill   = out_fill_q;

endmodule

// File: hdl/bhq_ctrl.sv
// ----------------------------------------------------------------------------
// bhq_ctrl
// Controller: sequences push sift-up and pop sift-down, owns the handshakes.
// ----------------------------------------------------------------------------
module bhq_ctrl
	import bhq_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_valid,
	output logic    s_ready,
	input  action_t action,
	output logic    m_valid,
	input  logic    m_ready,
	input  sts_t    sts,
	output cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_UP_CHK,
		S_UP_CMP,
		S_RD_TOP,
		S_RD_LST,
		S_DN_LD,
		S_DN_CHK,
		S_DN_LFT,
		S_DN_CMP,
		S_FIN
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   m_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (s_valid) begin
					cmd.start = 1'b1;
					if (action == ACT_PUSH) begin
						state_d = sts.full ? S_FIN : S_UP_CHK;
					end else begin
						state_d = sts.empty ? S_FIN : S_RD_TOP;
					end
				end
			end
			S_UP_CHK: begin
				if (sts.at_root) begin
					cmd.wr_en  = 1'b1;
					cmd.wr_sel = WD_HOLD;
					state_d    = S_FIN;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_PARENT;
					state_d    = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				cmd.wr_en = 1'b1;
				if (sts.up_less) begin
					cmd.wr_sel  = WD_READ;
					cmd.step_up = 1'b1;
					state_d     = S_UP_CHK;
				end else begin
					cmd.wr_sel = WD_HOLD;
					state_d    = S_FIN;
				end
			end
			S_RD_TOP: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RA_ROOT;
				state_d    = S_RD_LST;
			end
			S_RD_LST: begin
				cmd.cap_res = 1'b1;
				cmd.rd_en   = 1'b1;
				cmd.rd_sel  = RA_LAST;
				state_d     = S_DN_LD;
			end
			S_DN_LD: begin
				cmd.cap_hold = 1'b1;
				state_d      = S_DN_CHK;
			end
			S_DN_CHK: begin
				if (sts.leaf) begin
					cmd.wr_en  = 1'b1;
					cmd.wr_sel = WD_HOLD;
					state_d    = S_FIN;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_LEFT;
					state_d    = S_DN_LFT;
				end
			end
			S_DN_LFT: begin
				cmd.cap_left = 1'b1;
				if (sts.has_right) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RA_RIGHT;
				end
				state_d = S_DN_CMP;
			end
			S_DN_CMP: begin
				cmd.wr_en = 1'b1;
				if (sts.dn_right) begin
					cmd.wr_sel     = WD_READ;
					cmd.step_right = 1'b1;
					state_d        = S_DN_CHK;
				end else if (sts.dn_left) begin
					cmd.wr_sel    = WD_LEFT;
					cmd.step_left = 1'b1;
					state_d       = S_DN_CHK;
				end else begin
					cmd.wr_sel = WD_HOLD;
					state_d    = S_FIN;
				end
			end
			S_FIN: begin
				if (!m_valid_q || m_ready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				m_valid_q <= 1'b1;
			end else if (m_ready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign s_ready = (state_q == S_IDLE);
	assign m_valid = m_valid_q;

endmodule

// File: hdl/binary_min_heap_queue.sv
// ----------------------------------------------------------------------------
// binary_min_heap_queue
// Binary min-heap priority queue of (priority, tag) entries with push and pop.
// ----------------------------------------------------------------------------
// channel  dir  tdata                                         tuser
// s_axis   in   new_priority[15:0] new_tag[39:16]             action[0]
// m_axis   out  out_priority[15:0] out_tag[39:16] fill[50:40] status[1:0]
//
// One transaction at a time; a result may wait in the output register while
// the next transaction is taken. Push compares with one parent per level climbed
// and writes the new entry where it stops. Pop reads the root and the last entry,
// then descends level by level; each level costs one or two reads of the heap store.
// Errors skip the heap. A finished result holds until the output register frees.
// Reset clears the entry count and the handshakes; the store needs no pass.
// ----------------------------------------------------------------------------
`include "binary_min_heap_queue_assert.svh"

module binary_min_heap_queue
	import bhq_pkg::*;
#(
	parameter int HEAP_DEPTH = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [S_DATA_W-1:0] s_axis_tdata,  // new_priority, new_tag
	input  logic                s_axis_tuser,  // action
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [M_DATA_W-1:0] m_axis_tdata,  // out_priority, out_tag, fill_count
	output logic [1:0]          m_axis_tuser   // status
);

	cmd_t              cmd;
	sts_t              sts;
	status_t           out_status;
	entry_t            out_entry;
	logic [FILL_W-1:0] out_fill;
	entry_t            in_entry;
	action_t           action;

	assign in_entry = entry_t'(s_axis_tdata[ENTRY_W-1:0]);
	assign action   = action_t'(s_axis_tuser);

	bhq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_ready (s_axis_tready),
		.action  (action),
		.m_valid (m_axis_tvalid),
		.m_ready (m_axis_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	bhq_dp #(
		.HEAP_DEPTH (HEAP_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.action     (action),
		.in_entry   (in_entry),
		.out_status (out_status),
		.out_entry  (out_entry),
		.out_fill   (out_fill)
	);

	assign m_axis_tdata = {{(M_DATA_W - FILL_W - ENTRY_W){1'b0}}, out_fill, out_entry};
	assign m_axis_tuser = out_status;

	`BHQ_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "accept while busy")
	`BHQ_ASSERT_SAME(a_err_no_data, m_axis_tvalid && (m_axis_tuser != ST_DONE), m_axis_tdata[ENTRY_W-1:0] == '0, "error result with data")
	`BHQ_ASSERT_SAME(a_empty_fill, m_axis_tvalid && (m_axis_tuser == ST_EMPTY), m_axis_tdata[ENTRY_W+FILL_W-1:ENTRY_W] == '0, "empty pop with entries")
	`BHQ_ASSERT_SAME(a_status_code, m_axis_tvalid, (m_axis_tuser == ST_DONE) || (m_axis_tuser == ST_EMPTY) || (m_axis_tuser == ST_FULL), "bad status")

endmodule
